// ===== src/nvp_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// nvp_tok_pkg
// Shared types and character constants for the name/value pair tokeniser.
// ----------------------------------------------------------------------------
package nvp_tok_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_KEY_SPACE = 4'd0,
    PH_KEY       = 4'd1,
    PH_EQ_SPACE  = 4'd2,
    PH_EQUAL     = 4'd3,
    PH_DQUOTE    = 4'd4,
    PH_SQUOTE    = 4'd5,
    PH_RAW       = 4'd6,
    PH_AFTER     = 4'd7,
    PH_FAILED    = 4'd8,
    PH_FINISHED  = 4'd9
  } phase_t;

  // event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_KEY     = 3'd1,
    EV_VALUE   = 3'd2,
    EV_PAIR    = 3'd3,
    EV_OK      = 3'd4,
    EV_OK_PAIR = 3'd5,
    EV_FAIL    = 3'd6,
    EV_IGNORED = 3'd7
  } event_t;

  // characters of interest
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // input request payload
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] byte_out;
  } out_item_t;

  // parser state presented to the decoder
  typedef struct packed {
    phase_t phase;
    logic   key_seen;
    logic   allow_key_only;
  } parse_state_t;

  // decoder outcome
  typedef struct packed {
    phase_t    phase;
    logic      key_seen;
    out_item_t result;
  } parse_step_t;

endpackage

// ===== src/nvp_tok_decode.sv =====
// ----------------------------------------------------------------------------
// nvp_tok_decode
// Combinational step of the tokeniser: one request and the current state give
// the next state and the event to report.
// ----------------------------------------------------------------------------
module nvp_tok_decode (
  input  nvp_tok_pkg::parse_state_t state,
  input  nvp_tok_pkg::in_item_t     item,
  output nvp_tok_pkg::parse_step_t  step
);

  logic [7:0] b;
  logic       is_ws;
  logic       is_eq;
  logic       is_semi;
  logic       is_dq;
  logic       is_sq;

  // character classes
  always_comb begin
    b       = item.text_byte;
    is_ws   = (b <= nvp_tok_pkg::CH_SPACE);
    is_eq   = (b == nvp_tok_pkg::CH_EQUAL);
    is_semi = (b == nvp_tok_pkg::CH_SEMI);
    is_dq   = (b == nvp_tok_pkg::CH_DQUOTE);
    is_sq   = (b == nvp_tok_pkg::CH_SQUOTE);
  end

  nvp_tok_pkg::event_t ev;

  // next phase and event
  always_comb begin
    step.phase    = state.phase;
    step.key_seen = state.key_seen;
    step.result.byte_out = 8'd0;
    ev = nvp_tok_pkg::EV_IGNORED;

    if (item.end_of_text) begin
      case (state.phase)
        nvp_tok_pkg::PH_KEY, nvp_tok_pkg::PH_EQ_SPACE, nvp_tok_pkg::PH_EQUAL: begin
          if (state.allow_key_only && state.key_seen) begin
            step.phase = nvp_tok_pkg::PH_FINISHED;
            ev         = nvp_tok_pkg::EV_OK_PAIR;
          end else begin
            step.phase = nvp_tok_pkg::PH_FAILED;
            ev         = nvp_tok_pkg::EV_FAIL;
          end
        end
        nvp_tok_pkg::PH_RAW: begin
          step.phase = nvp_tok_pkg::PH_FINISHED;
          ev         = nvp_tok_pkg::EV_OK_PAIR;
        end
        nvp_tok_pkg::PH_KEY_SPACE, nvp_tok_pkg::PH_AFTER, nvp_tok_pkg::PH_FINISHED: begin
          step.phase = nvp_tok_pkg::PH_FINISHED;
          ev         = nvp_tok_pkg::EV_OK;
        end
        default: begin
          step.phase = nvp_tok_pkg::PH_FAILED;
          ev         = nvp_tok_pkg::EV_FAIL;
        end
      endcase
    end else begin
      case (state.phase)
        nvp_tok_pkg::PH_KEY_SPACE, nvp_tok_pkg::PH_KEY: begin
          // leading whitespace before a key is dropped
          if (state.phase == nvp_tok_pkg::PH_KEY_SPACE && is_ws) begin
            ev = nvp_tok_pkg::EV_IGNORED;
          end else if (is_eq) begin
            step.phase = nvp_tok_pkg::PH_EQUAL;
            ev         = nvp_tok_pkg::EV_NONE;
          end else if (is_ws) begin
            step.phase = nvp_tok_pkg::PH_EQ_SPACE;
            ev         = nvp_tok_pkg::EV_NONE;
          end else if (is_semi) begin
            if (state.allow_key_only) begin
              step.key_seen = 1'b0;
              step.phase    = nvp_tok_pkg::PH_KEY_SPACE;
              ev            = nvp_tok_pkg::EV_PAIR;
            end else begin
              step.phase = nvp_tok_pkg::PH_FAILED;
              ev         = nvp_tok_pkg::EV_FAIL;
            end
          end else if (is_dq || is_sq) begin
            step.phase = nvp_tok_pkg::PH_FAILED;
            ev         = nvp_tok_pkg::EV_FAIL;
          end else begin
            step.phase           = nvp_tok_pkg::PH_KEY;
            step.key_seen        = 1'b1;
            step.result.byte_out = b;
            ev                   = nvp_tok_pkg::EV_KEY;
          end
        end
        nvp_tok_pkg::PH_EQ_SPACE: begin
          if (is_eq) begin
            step.phase = nvp_tok_pkg::PH_EQUAL;
            ev         = nvp_tok_pkg::EV_NONE;
          end else if (is_semi) begin
            if (state.allow_key_only) begin
              step.key_seen = 1'b0;
              step.phase    = nvp_tok_pkg::PH_KEY_SPACE;
              ev            = nvp_tok_pkg::EV_PAIR;
            end else begin
              step.phase = nvp_tok_pkg::PH_FAILED;
              ev         = nvp_tok_pkg::EV_FAIL;
            end
          end else if (!is_ws) begin
            step.phase = nvp_tok_pkg::PH_FAILED;
            ev         = nvp_tok_pkg::EV_FAIL;
          end else begin
            ev = nvp_tok_pkg::EV_IGNORED;
          end
        end
        nvp_tok_pkg::PH_EQUAL: begin
          if (is_semi) begin
            if (state.allow_key_only) begin
              step.key_seen = 1'b0;
              step.phase    = nvp_tok_pkg::PH_KEY_SPACE;
              ev            = nvp_tok_pkg::EV_PAIR;
            end else begin
              step.phase = nvp_tok_pkg::PH_FAILED;
              ev         = nvp_tok_pkg::EV_FAIL;
            end
          end else if (is_dq) begin
            step.phase = nvp_tok_pkg::PH_DQUOTE;
            ev         = nvp_tok_pkg::EV_NONE;
          end else if (is_sq) begin
            step.phase = nvp_tok_pkg::PH_SQUOTE;
            ev         = nvp_tok_pkg::EV_NONE;
          end else begin
            step.phase           = nvp_tok_pkg::PH_RAW;
            step.result.byte_out = b;
            ev                   = nvp_tok_pkg::EV_VALUE;
          end
        end
        nvp_tok_pkg::PH_DQUOTE, nvp_tok_pkg::PH_SQUOTE: begin
          // only the quote that opened the value closes it
          if ((state.phase == nvp_tok_pkg::PH_DQUOTE && is_dq) ||
              (state.phase == nvp_tok_pkg::PH_SQUOTE && is_sq)) begin
            step.key_seen = 1'b0;
            step.phase    = nvp_tok_pkg::PH_AFTER;
            ev            = nvp_tok_pkg::EV_PAIR;
          end else begin
            step.result.byte_out = b;
            ev                   = nvp_tok_pkg::EV_VALUE;
          end
        end
        nvp_tok_pkg::PH_RAW: begin
          if (is_semi) begin
            step.key_seen = 1'b0;
            step.phase    = nvp_tok_pkg::PH_KEY_SPACE;
            ev            = nvp_tok_pkg::EV_PAIR;
          end else begin
            step.result.byte_out = b;
            ev                   = nvp_tok_pkg::EV_VALUE;
          end
        end
        nvp_tok_pkg::PH_AFTER: begin
          // control bytes may trail a quoted value, a space may not
          if (is_semi) begin
            step.phase = nvp_tok_pkg::PH_KEY_SPACE;
            ev         = nvp_tok_pkg::EV_NONE;
          end else if (b < nvp_tok_pkg::CH_SPACE) begin
            ev = nvp_tok_pkg::EV_IGNORED;
          end else begin
            step.phase = nvp_tok_pkg::PH_FAILED;
            ev         = nvp_tok_pkg::EV_FAIL;
          end
        end
        default: begin
          ev = nvp_tok_pkg::EV_IGNORED;
        end
      endcase
    end

    step.result.event_kind = ev;
  end

endmodule

// ===== src/name_value_pair_tokenizer.sv =====
// ----------------------------------------------------------------------------
// name_value_pair_tokenizer
// Splits a byte stream of key=value pairs separated by semicolons into one
// event per request.
// ----------------------------------------------------------------------------
// Each request (a text byte or an end-of-text mark) gives exactly one result:
// key byte, value byte, pair done, finish ok, finish ok with a last pair,
// failed, ignored or none. Requests are taken at one per cycle unless the
// result register is full and not being read. Each request passes through an
// input register and then, together with the phase register update, into
// the result register. The only loop is the phase and key-seen register,
// updated in the same cycle that a result is registered. The allow_key_only
// register is to be written through the cfg channel only while the block is
// idle, which the block itself does not enforce; it applies from the next request on.
module name_value_pair_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nvp_tok_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nvp_tok_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  logic                      in_full;
  nvp_tok_pkg::in_item_t     in_reg;
  logic                      out_full;
  nvp_tok_pkg::out_item_t    out_reg;
  nvp_tok_pkg::phase_t       phase;
  logic                      key_seen;
  logic                      allow_key_only;
  logic                      advance;
  nvp_tok_pkg::parse_state_t state;
  nvp_tok_pkg::parse_step_t  step;

  // handshake
  assign advance   = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_full;
  assign out_data  = out_reg;

  // decoder
  assign state.phase          = phase;
  assign state.key_seen       = key_seen;
  assign state.allow_key_only = allow_key_only;

  nvp_tok_decode u_decode (
    .state (state),
    .item  (in_reg),
    .step  (step)
  );

  // control and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_full       <= 1'b0;
      phase          <= nvp_tok_pkg::PH_KEY_SPACE;
      key_seen       <= 1'b0;
      allow_key_only <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        allow_key_only <= cfg_data;
      end
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
        phase    <= step.phase;
        key_seen <= step.key_seen;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (advance) begin
      out_reg <= step.result;
    end
  end

endmodule
